### rtl/core/afv_pkg.sv
package afv_pkg;

  // Frame geometry defaults
  localparam int FRAME_BYTES_DEF = 32;
  localparam int CRC_SPAN_DEF    = 26;

  // Byte counter saturates at its all-ones value
  localparam int          CNT_W     = 6;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0]  ACK_TYPE     = 8'h02;
  localparam logic [7:0]  GATEWAY_NODE = 8'h00;

  localparam logic [7:0]  EXP_VERSION_RST  = 8'h01;
  localparam logic [15:0] EXP_SEQUENCE_RST = 16'h0000;

  // Fixed capture positions in the frame header
  localparam logic [CNT_W-1:0] POS_VERSION = 6'd0;
  localparam logic [CNT_W-1:0] POS_TYPE    = 6'd1;
  localparam logic [CNT_W-1:0] POS_NODE    = 6'd2;
  localparam logic [CNT_W-1:0] POS_SEQ_LO  = 6'd4;
  localparam logic [CNT_W-1:0] POS_SEQ_HI  = 6'd5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXP_VERSION  = 1'b0,
    CFG_EXP_SEQUENCE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_ACK_OK       = 3'd0,
    ST_BAD_LEN      = 3'd1,
    ST_VER_MISMATCH = 3'd2,
    ST_CRC_MISMATCH = 3'd3,
    ST_NOT_GW_ACK   = 3'd4,
    ST_STALE_SEQ    = 3'd5
  } status_t;

  // Per-frame capture state
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [15:0]      crc;
    logic [7:0]       version;
    logic [7:0]       msg_type;
    logic [7:0]       node;
    logic [15:0]      seq;
    logic [15:0]      crc_rx;
  } frame_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/core/ack_frame_validator_core.sv
// Channel | Dir | Ports                                            | Handshake
// in      | in  | in_data_byte, in_last_byte, in_link_rssi         | in_valid / in_stall
// out     | out | out_status, out_ack_rssi                         | out_valid / out_stall
// cfg     | in  | cfg_index, cfg_wdata                             | cfg_we, no wait
//
// One byte per clock unless a last byte waits on a stalled result. An item is
// held in the input register, then the CRC byte update, capture and checks run
// combinationally into the result register, from which a last byte's status is
// offered on the result port.
// Reset is synchronous (rst_n low); no clearing pass, ready right after reset.
// A waiting result stalls only a following last byte; other bytes keep moving.
module ack_frame_validator_core
  import afv_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int CRC_SPAN    = CRC_SPAN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic signed [7:0]     in_link_rssi,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic signed [7:0]     out_ack_rssi,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] FRAME_LEN_C = CNT_W'(FRAME_BYTES);

  // Config registers
  logic [7:0]  exp_version_r;
  logic [15:0] exp_sequence_r;

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_data_r;
  logic              s1_last_r;
  logic signed [7:0] s1_rssi_r;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic signed [7:0] ack_rssi_r, ack_rssi_nxt;

  logic   in_acc;
  logic   out_free;
  logic   go;
  frame_t frm_cur;
  frame_t frm_upd;

  // Result slot is free if empty or being drained this edge
  assign out_free = !out_valid_r || !out_stall;
  // Non-last bytes never need the result slot
  assign go       = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !go;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r  <= EXP_VERSION_RST;
      exp_sequence_r <= EXP_SEQUENCE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EXP_VERSION:  exp_version_r  <= cfg_wdata[7:0];
        CFG_EXP_SEQUENCE: exp_sequence_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)  s1_valid_nxt = 1'b1;
    else if (go) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_rssi_r <= in_link_rssi;
    end
  end

  afv_frame_track #(
    .CRC_SPAN (CRC_SPAN)
  ) u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (go),
    .last  (s1_last_r),
    .data  (s1_data_r),
    .cur   (frm_cur),
    .upd   (frm_upd)
  );

  // Checks in priority order, on state that includes the last byte
  always_comb begin
    if (frm_upd.count != FRAME_LEN_C)
      status_nxt = ST_BAD_LEN;
    else if (frm_upd.version != exp_version_r)
      status_nxt = ST_VER_MISMATCH;
    else if (frm_upd.crc_rx != frm_upd.crc)
      status_nxt = ST_CRC_MISMATCH;
    else if (frm_upd.msg_type != ACK_TYPE || frm_upd.node != GATEWAY_NODE)
      status_nxt = ST_NOT_GW_ACK;
    else if (frm_upd.seq != exp_sequence_r)
      status_nxt = ST_STALE_SEQ;
    else
      status_nxt = ST_ACK_OK;
    ack_rssi_nxt = (status_nxt == ST_ACK_OK) ? s1_rssi_r : 8'sd0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && s1_last_r)           out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_last_r) begin
      status_r   <= status_nxt;
      ack_rssi_r <= ack_rssi_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_ack_rssi = ack_rssi_r;

  // RSSI is only reported for an accepted ack
  a_rssi_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_ACK_OK |-> ack_rssi_r == 8'sd0)
    else $error("ack_rssi nonzero on rejected frame");

  // Frame state cleared after the last byte goes through
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    go && s1_last_r |=> frm_cur.count == '0 && frm_cur.crc == CRC_INIT)
    else $error("frame state not cleared after last byte");

  // Only a last byte facing a full, stalled result slot holds the input
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(go && s1_last_r))
    else $error("result overwritten while stalled");

endmodule

### rtl/core/afv_frame_track.sv
module afv_frame_track
  import afv_pkg::*;
#(
  parameter int CRC_SPAN = CRC_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       last,
  input  logic [7:0] data,
  output frame_t     cur,
  output frame_t     upd
);

  localparam logic [CNT_W-1:0] SPAN_C   = CNT_W'(CRC_SPAN);
  localparam logic [CNT_W-1:0] CRC_LO_C = CNT_W'(CRC_SPAN);
  localparam logic [CNT_W-1:0] CRC_HI_C = CNT_W'(CRC_SPAN + 1);

  localparam frame_t FRAME_CLR = '{
    count:    '0,
    crc:      CRC_INIT,
    version:  '0,
    msg_type: '0,
    node:     '0,
    seq:      '0,
    crc_rx:   '0
  };

  frame_t frame_r;
  frame_t frame_nxt;
  logic [CNT_W-1:0] pos;

  assign pos = frame_r.count;
  assign cur = frame_r;

  // State as it stands after this byte, before the frame-end clear
  always_comb begin
    upd = frame_r;
    if (pos < SPAN_C) upd.crc = crc_byte(frame_r.crc, data);
    if (pos == POS_VERSION) upd.version  = data;
    if (pos == POS_TYPE)    upd.msg_type = data;
    if (pos == POS_NODE)    upd.node     = data;
    if (pos == POS_SEQ_LO)  upd.seq[7:0]  = data;
    if (pos == POS_SEQ_HI)  upd.seq[15:8] = data;
    if (pos == CRC_LO_C)    upd.crc_rx[7:0]  = data;
    if (pos == CRC_HI_C)    upd.crc_rx[15:8] = data;
    if (frame_r.count != COUNT_MAX) upd.count = frame_r.count + 1'b1;
  end

  always_comb begin
    frame_nxt = frame_r;
    if (step) begin
      frame_nxt = last ? FRAME_CLR : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= FRAME_CLR;
    end else begin
      frame_r <= frame_nxt;
    end
  end

endmodule
